// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition must hold at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: always");
// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next cycle");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/rpb_pkg.sv =====
// Types and constants for the palette-building bitplane converter.
// No dependencies; used by rpb_packer, the top module and the bench.
`default_nettype none
package rpb_pkg;

	localparam int COLOUR_W = 24;
	localparam int WIDTH_W = 13;
	localparam int PLANES = 4;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;
	localparam logic [2:0] GROUP_LAST = 3'h7;
	localparam logic [7:0] LEFT_BIT = 8'h80;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [3:0] color_index;
		logic       new_color;
		logic [4:0] colors_used;
		logic       bytes_ready;
		logic [7:0] plane0_byte;
		logic [7:0] plane1_byte;
		logic [7:0] plane2_byte;
		logic [7:0] plane3_byte;
		logic       end_of_row;
		logic       palette_overflow;
	} result_t;

	typedef struct packed {
		logic                   bytes_ready;
		logic                   end_of_row;
		logic [PLANES-1:0][7:0] planes;
	} pack_t;

endpackage
`default_nettype wire

// ===== design/rpb_cell.sv =====
// One palette slot: holds a colour, compares it with the incoming pixel
// and folds its hit into the chain from its lower neighbour. Needs no package.
`default_nettype none
module rpb_cell #(
	parameter int SLOT = 0,
	parameter int CNT_W = 5,
	parameter int IDX_W = 4
) (
	input  wire logic             clk,
	input  wire logic [23:0]      colour,
	input  wire logic [CNT_W-1:0] fill_count,
	input  wire logic             append,
	input  wire logic             hit_in,
	input  wire logic [IDX_W-1:0] idx_in,
	output logic                  hit_out,
	output logic [IDX_W-1:0]      idx_out
);

	logic [23:0] entry_q;
	logic        occupied;
	logic        hit;

	assign occupied = fill_count > CNT_W'(SLOT);
	assign hit = occupied && (entry_q == colour);
	// palette holds no duplicates, so at most one cell hits
	assign hit_out = hit_in | hit;
	assign idx_out = idx_in | (hit ? IDX_W'(SLOT) : '0);

	always_ff @(posedge clk) begin
		if (append && (fill_count == CNT_W'(SLOT))) begin
			entry_q <= colour;
		end
	end

endmodule
`default_nettype wire

// ===== design/rpb_packer.sv =====
// Row position and plane accumulators: packs index bits MSB-first into
// four plane bytes. Depends on rpb_pkg.
`default_nettype none
module rpb_packer #(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          advance,
	input  wire logic [rpb_pkg::PLANES-1:0]    index,
	input  wire logic [rpb_pkg::WIDTH_W-1:0]   image_width,
	output rpb_pkg::pack_t                     pack
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int EW = (COL_W + 1 > rpb_pkg::WIDTH_W) ? COL_W + 1 : rpb_pkg::WIDTH_W;

	logic [COL_W-1:0]                    column_q;
	logic [rpb_pkg::PLANES-1:0][7:0]     acc_q;
	logic [rpb_pkg::PLANES-1:0][7:0]     acc_new;
	logic [EW-1:0]                       width_ext;
	logic [EW-1:0]                       eff_width;
	logic [EW-1:0]                       col_inc;
	logic [7:0]                          set_mask;
	logic                                eor;
	logic                                ready;

	always_comb begin
		width_ext = EW'(image_width);
		eff_width = width_ext;
		if (width_ext == '0) begin
			eff_width = EW'(1);
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			eff_width = EW'(MAX_WIDTH);
		end
	end

	assign col_inc = EW'(column_q) + EW'(1);
	assign eor = col_inc >= eff_width;
	assign ready = eor || (column_q[2:0] == rpb_pkg::GROUP_LAST);
	assign set_mask = rpb_pkg::LEFT_BIT >> column_q[2:0];

	always_comb begin
		for (int p = 0; p < rpb_pkg::PLANES; p++) begin
			acc_new[p] = acc_q[p] | (index[p] ? set_mask : 8'h00);
		end
	end

	assign pack.bytes_ready = ready;
	assign pack.end_of_row = eor;
	assign pack.planes = ready ? acc_new : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			acc_q <= '0;
		end else if (advance) begin
			acc_q <= ready ? '0 : acc_new;
			// width never exceeds MAX_WIDTH, so the increment fits unless the row ends
			column_q <= eor ? '0 : col_inc[COL_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== design/rgb_palette_to_bitplanes_top.sv =====
// Takes one RGB pixel per cycle while in_ready is high, assigns it a slot in
// a palette built on the fly by a row of compare cells, and packs the 4-bit
// indices into four plane bytes per group of eight pixels or at row end. The
// result of a request goes to the output register, or to the one-deep skid
// stage behind it while that register is held; the skid stage keeps the
// input open for one more request while a result waits, so the rate is one
// pixel per cycle whenever the consumer keeps up. The palette lookup compares
// all slots in parallel and combinationally in the cell row. image_width may
// only be written while the block is idle.
// Depends on rpb_pkg, rpb_cell, rpb_packer and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rgb_palette_to_bitplanes_top #(
	parameter int PALETTE_ENTRIES = 16,
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire rpb_pkg::pixel_t             in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output rpb_pkg::result_t                 out_data,
	input  wire logic                        cfg_we,
	input  wire logic [rpb_pkg::WIDTH_W-1:0] cfg_wdata
);

	localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);
	localparam int IDX_W = $clog2(PALETTE_ENTRIES);

	logic [rpb_pkg::WIDTH_W-1:0]  width_q;
	logic [CNT_W-1:0]             count_q;
	logic                         ovf_q;
	logic                         out_valid_q;
	logic                         skid_valid_q;
	rpb_pkg::result_t             out_q;
	rpb_pkg::result_t             skid_q;

	logic                         load;
	logic                         drain;
	logic [23:0]                  colour;
	logic [PALETTE_ENTRIES:0]     hit_chain;
	logic [PALETTE_ENTRIES:0][IDX_W-1:0] idx_chain;
	logic                         found;
	logic                         full;
	logic                         added;
	logic [IDX_W-1:0]             slot;
	logic [3:0]                   color_idx;
	logic [CNT_W-1:0]             count_next;
	logic                         ovf_next;
	rpb_pkg::pack_t               pack;
	rpb_pkg::result_t             result;

	assign in_ready = !skid_valid_q;
	assign load = in_valid && in_ready;
	assign drain = !out_valid_q || out_ready;
	assign colour = {in_data.red, in_data.green, in_data.blue};

	assign hit_chain[0] = 1'b0;
	assign idx_chain[0] = '0;

	for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
		rpb_cell #(
			.SLOT(i),
			.CNT_W(CNT_W),
			.IDX_W(IDX_W)
		) u_cell (
			.clk(clk),
			.colour(colour),
			.fill_count(count_q),
			.append(load && added),
			.hit_in(hit_chain[i]),
			.idx_in(idx_chain[i]),
			.hit_out(hit_chain[i+1]),
			.idx_out(idx_chain[i+1])
		);
	end

	assign found = hit_chain[PALETTE_ENTRIES];
	assign full = count_q == CNT_W'(PALETTE_ENTRIES);
	assign added = !found && !full;

	always_comb begin
		slot = '0;
		if (found) begin
			slot = idx_chain[PALETTE_ENTRIES];
		end else if (added) begin
			slot = count_q[IDX_W-1:0];
		end
	end

	assign color_idx = 4'(slot);
	assign count_next = added ? count_q + CNT_W'(1) : count_q;
	assign ovf_next = ovf_q || (!found && full);

	rpb_packer #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_packer (
		.clk(clk),
		.arst_n(arst_n),
		.advance(load),
		.index(color_idx),
		.image_width(width_q),
		.pack(pack)
	);

	always_comb begin
		result.color_index = color_idx;
		result.new_color = added;
		result.colors_used = 5'(count_next);
		result.bytes_ready = pack.bytes_ready;
		result.plane0_byte = pack.planes[0];
		result.plane1_byte = pack.planes[1];
		result.plane2_byte = pack.planes[2];
		result.plane3_byte = pack.planes[3];
		result.end_of_row = pack.end_of_row;
		result.palette_overflow = ovf_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= rpb_pkg::WIDTH_RESET;
			count_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				width_q <= cfg_wdata;
			end
			if (load) begin
				count_q <= count_next;
				ovf_q <= ovf_next;
			end
		end
	end

	// output register with a one-deep skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= load;
			end
		end else if (load) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			out_q <= skid_valid_q ? skid_q : result;
		end
		if (!drain && load) begin
			skid_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`ASSERT_ALWAYS(a_skid_behind_out, clk, arst_n, !skid_valid_q || out_valid_q)
	`ASSERT_ALWAYS(a_count_bounded, clk, arst_n, count_q <= CNT_W'(PALETTE_ENTRIES))
	`ASSERT_NEXT(a_overflow_sticky, clk, arst_n, ovf_q, ovf_q)
	`ASSERT_IMPLIES(a_new_colour_counted, clk, arst_n, out_valid_q && out_q.new_color, out_q.colors_used != 5'd0)
	`ASSERT_IMPLIES(a_idle_planes_zero, clk, arst_n, out_valid_q && !out_q.bytes_ready, (out_q.plane0_byte | out_q.plane1_byte | out_q.plane2_byte | out_q.plane3_byte) == 8'h00)

endmodule
`default_nettype wire

// ===== tb/sv/rgb_palette_to_bitplanes_top_tb.sv =====
// Self-checking bench for the palette-building bitplane converter: directed and random
// pixel streams against a built-in palette and plane-byte predictor.
// Depends on rpb_pkg and rgb_palette_to_bitplanes_top.
`default_nettype none
module rgb_palette_to_bitplanes_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 16;
	localparam int WIDEST_ROW = 4096;
	localparam int STALL_LIMIT = 1000;
	localparam int REPORT_LIMIT = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rpb_pkg::pixel_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rpb_pkg::result_t out_data;
	logic cfg_we = 1'b0;
	logic [rpb_pkg::WIDTH_W-1:0] cfg_wdata = '0;

	// predicted block state
	logic [23:0] pal_colour [SLOTS];
	int pal_fill = 0;
	int row_col = 0;
	logic [7:0] plane_acc [rpb_pkg::PLANES];
	bit overflow_flag = 1'b0;
	logic [rpb_pkg::WIDTH_W-1:0] width_reg = rpb_pkg::WIDTH_RESET;

	rpb_pkg::result_t queued_pixel_results [$];
	int pixels_sent = 0;
	int results_taken = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 25;
	int recv_idle_pct = 63;

	rgb_palette_to_bitplanes_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic rpb_pkg::result_t map_pixel(rpb_pkg::pixel_t px);
		logic [23:0] colour;
		logic [3:0] slot;
		bit hit;
		bit added;
		bit row_end;
		bit group_done;
		int span;
		int bitpos;
		rpb_pkg::result_t r;
		colour = px;
		slot = '0;
		hit = 1'b0;
		added = 1'b0;
		for (int i = 0; i < pal_fill; i++) begin
			if (!hit && pal_colour[i] == colour) begin
				slot = 4'(i);
				hit = 1'b1;
			end
		end
		if (!hit) begin
			if (pal_fill < SLOTS) begin
				pal_colour[pal_fill] = colour;
				slot = 4'(pal_fill);
				pal_fill++;
				added = 1'b1;
			end else begin
				// full palette: flag it and fall back to slot zero
				overflow_flag = 1'b1;
				slot = '0;
			end
		end
		if (width_reg == '0)
			span = 1;
		else if (int'(width_reg) > WIDEST_ROW)
			span = WIDEST_ROW;
		else
			span = int'(width_reg);
		bitpos = 7 - (row_col % 8);
		for (int p = 0; p < rpb_pkg::PLANES; p++)
			plane_acc[p][bitpos] = plane_acc[p][bitpos] | slot[p];
		row_end = (row_col + 1 >= span);
		group_done = row_end || (3'(row_col) == rpb_pkg::GROUP_LAST);
		r.color_index = slot;
		r.new_color = added;
		r.colors_used = 5'(pal_fill);
		r.bytes_ready = group_done;
		r.plane0_byte = group_done ? plane_acc[0] : 8'h00;
		r.plane1_byte = group_done ? plane_acc[1] : 8'h00;
		r.plane2_byte = group_done ? plane_acc[2] : 8'h00;
		r.plane3_byte = group_done ? plane_acc[3] : 8'h00;
		r.end_of_row = row_end;
		r.palette_overflow = overflow_flag;
		if (group_done)
			plane_acc = '{default: 8'h00};
		row_col = row_end ? 0 : row_col + 1;
		return r;
	endfunction

	function automatic rpb_pkg::pixel_t fresh_colour();
		rpb_pkg::pixel_t c;
		bit known;
		do begin
			c = rpb_pkg::pixel_t'(24'($urandom));
			known = 1'b0;
			for (int i = 0; i < pal_fill; i++)
				if (pal_colour[i] == c)
					known = 1'b1;
		end while (known);
		return c;
	endfunction

	// mostly known colours, some new ones and some one bit away from a known one
	function automatic rpb_pkg::pixel_t mixed_colour(bit may_overflow);
		rpb_pkg::pixel_t c;
		if (pal_fill > 0 && $urandom_range(99) < 85)
			return rpb_pkg::pixel_t'(pal_colour[$urandom_range(pal_fill - 1)]);
		if (!may_overflow && pal_fill >= SLOTS)
			return rpb_pkg::pixel_t'(pal_colour[$urandom_range(SLOTS - 1)]);
		c = rpb_pkg::pixel_t'(24'($urandom));
		if (pal_fill > 0 && $urandom_range(1) == 1)
			c = rpb_pkg::pixel_t'(pal_colour[$urandom_range(pal_fill - 1)]
				^ (24'h1 << $urandom_range(23)));
		return c;
	endfunction

	task automatic report_field(string field, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("result %0d: %s expected %h got %h", results_taken, field,
					want, got);
		end
	endtask

	task automatic compare_result(rpb_pkg::result_t want, rpb_pkg::result_t got);
		report_field("color_index", 8'(want.color_index), 8'(got.color_index));
		report_field("new_color", 8'(want.new_color), 8'(got.new_color));
		report_field("colors_used", 8'(want.colors_used), 8'(got.colors_used));
		report_field("bytes_ready", 8'(want.bytes_ready), 8'(got.bytes_ready));
		report_field("plane0_byte", want.plane0_byte, got.plane0_byte);
		report_field("plane1_byte", want.plane1_byte, got.plane1_byte);
		report_field("plane2_byte", want.plane2_byte, got.plane2_byte);
		report_field("plane3_byte", want.plane3_byte, got.plane3_byte);
		report_field("end_of_row", 8'(want.end_of_row), 8'(got.end_of_row));
		report_field("palette_overflow", 8'(want.palette_overflow),
			8'(got.palette_overflow));
	endtask

	always @(posedge clk) begin : result_watch
		rpb_pkg::result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_taken++;
				if (queued_pixel_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("result %0d: none expected, got %h", results_taken, out_data);
				end else begin
					want = queued_pixel_results.pop_front();
					compare_result(want, out_data);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("rgb_palette_to_bitplanes_top_tb: done, errors");
				$finish;
			end
		end
	end

	// hold the request until taken, then predict its result
	task automatic send_pixel(rpb_pkg::pixel_t px);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= px;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		queued_pixel_results.push_back(map_pixel(px));
		pixels_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (results_taken < pixels_sent)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_width(logic [rpb_pkg::WIDTH_W-1:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		width_reg = value;
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(int count, bit may_overflow);
		for (int n = 0; n < count; n++) begin
			send_pixel(mixed_colour(may_overflow));
			if ($urandom_range(149) == 0)
				wait_drained();
		end
	endtask

	task automatic test_palette_build();
		send_pixel(24'h000000);
		send_pixel(24'hFFFFFF);
		send_pixel(24'hFF0000);
		send_pixel(24'h00FF00);
		send_pixel(24'h0000FF);
		send_pixel(24'h000000);
		send_pixel(24'h010101);
		send_pixel(24'h808080);
		send_pixel(24'hFFFFFF);
		send_pixel(24'h0000FF);
		send_pixel(24'h7F7F7F);
	endtask

	task automatic test_width_edges();
		// shrink below the current column: the next pixel closes the row
		write_width(13'd5);
		send_pixel(24'h808080);
		for (int n = 0; n < 5; n++)
			send_pixel(rpb_pkg::pixel_t'(pal_colour[n + 3]));
		// zero width behaves as one pixel per row
		write_width(13'd0);
		send_pixel(24'h7F7F7F);
		send_pixel(24'h010101);
		send_pixel(24'hFF0000);
	endtask

	task automatic test_random_narrow_rows();
		send_idle_pct = 25;
		recv_idle_pct = 63;
		write_width(13'd13);
		run_random(450, 1'b0);
	endtask

	task automatic test_palette_overflow();
		while (pal_fill < SLOTS)
			send_pixel(fresh_colour());
		send_pixel(fresh_colour());
		send_pixel(rpb_pkg::pixel_t'(pal_colour[SLOTS - 1]));
		send_pixel(fresh_colour());
	endtask

	task automatic test_random_byte_rows();
		send_idle_pct = 63;
		recv_idle_pct = 25;
		write_width(13'd8);
		run_random(400, 1'b1);
	endtask

	task automatic test_widest_rows();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_width(13'd4096);
		run_random(250, 1'b1);
		// above the maximum saturates to it
		write_width(13'h1FFF);
		run_random(250, 1'b1);
	endtask

	task automatic test_random_width_sweep();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_width(13'd1);
		run_random(60, 1'b1);
		write_width(13'd3);
		run_random(60, 1'b1);
		write_width(13'd9);
		run_random(60, 1'b1);
		write_width(13'd17);
		run_random(60, 1'b1);
		write_width(13'd100);
		run_random(60, 1'b1);
	endtask

	initial begin
		plane_acc = '{default: 8'h00};
		pal_colour = '{default: 24'h000000};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_palette_build();
		test_width_edges();
		test_random_narrow_rows();
		test_palette_overflow();
		test_random_byte_rows();
		test_widest_rows();
		test_random_width_sweep();
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && queued_pixel_results.size() == 0)
			$display("rgb_palette_to_bitplanes_top_tb: done, clean");
		else
			$display("rgb_palette_to_bitplanes_top_tb: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
